FILE: rtl/core/lmc_pkg.sv
// Shared types and fixed constants for the 3x3 strict local minimum counter.
// No dependencies; imported by every module of the block.
package lmc_pkg;

	// register port
	localparam int CFG_AW      = 3;
	localparam int CFG_DW      = 32;
	localparam int ROW_FIELD_W = 13;
	localparam int COL_FIELD_W = 11;

	// result
	localparam int COUNT_W = 21;

	// result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_PW    = $clog2(RES_DEPTH);
	localparam int RES_CW    = $clog2(RES_DEPTH + 1);

	typedef enum logic {
		REG_ROW_COUNT    = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} lmc_reg_t;

	// where the incoming cell sits in the matrix
	typedef struct packed {
		logic row_ge1;
		logic row_ge2;
		logic col_ge1;
		logic col_ge2;
		logic last_row;
		logic last_col;
	} lmc_pos_t;

	// judged minima for one transaction
	typedef struct packed {
		logic       valid;
		logic       frame_end;
		logic [2:0] hits;
	} lmc_hit_t;

endpackage

FILE: rtl/core/lmc_line_mem.sv
// Line store: one synchronous memory holding the two rows above the incoming row.
// Depends on lmc_pkg. Read at accept, written back in the following cycle, with forwarding.
module lmc_line_mem
	import lmc_pkg::*;
#(
	parameter int VW    = 16,
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	input  logic signed [VW-1:0]       cell_in,
	input  lmc_pos_t                   pos,
	output logic                       valid_s1,
	output logic signed [VW-1:0]       cell_s1,
	output logic signed [VW-1:0]       top_s1,
	output logic signed [VW-1:0]       mid_s1,
	output lmc_pos_t                   pos_s1
);

	localparam int AW = $clog2(DEPTH);

	// entry = {upper row, middle row}
	logic [2*VW-1:0] mem [DEPTH];
	logic [2*VW-1:0] rd_q;
	logic [2*VW-1:0] fwd_data_s1;
	logic [2*VW-1:0] entry_s1;
	logic [2*VW-1:0] wr_data;
	logic            fwd_s1;
	logic [AW-1:0]   addr_s1;

	always_ff @(posedge clk) begin
		if (valid_s1)
			mem[addr_s1] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= rd_en;
	end

	// one-column matrix: the same entry is read while it is being written
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cell_s1     <= cell_in;
			pos_s1      <= pos;
			addr_s1     <= rd_addr;
			fwd_s1      <= valid_s1 && (addr_s1 == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	assign entry_s1 = fwd_s1 ? fwd_data_s1 : rd_q;
	assign top_s1   = entry_s1[2*VW-1:VW];
	assign mid_s1   = entry_s1[VW-1:0];
	// rows move up by one
	assign wr_data  = {mid_s1, cell_s1};

endmodule

FILE: rtl/core/lmc_window.sv
// 3x3 window registers and the neighbor compares for up to four centers per cell.
// Depends on lmc_pkg. Fed by lmc_line_mem, feeds lmc_result.
module lmc_window
	import lmc_pkg::*;
#(
	parameter int VW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  logic signed [VW-1:0] cell_s1,
	input  logic signed [VW-1:0] top_s1,
	input  logic signed [VW-1:0] mid_s1,
	input  lmc_pos_t             pos_s1,
	output lmc_hit_t             hit_s3
);

	typedef logic signed [VW-1:0] val_t;

	// [row][col]: row 2 and col 2 belong to the newest cell
	val_t     win_q [3][3];
	logic     valid_s2;
	lmc_pos_t pos_s2;
	logic [2:0] rmask;
	logic [2:0] cmask;
	logic       hit_a;
	logic       hit_b;
	logic       hit_c;
	logic       hit_d;
	logic [2:0] hits;

	function automatic logic judge(input val_t w [3][3], input int ci, input int cj,
			input logic [2:0] rm, input logic [2:0] cm);
		logic ok;
		int   di;
		int   dj;
		ok = 1'b1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				di = i - ci;
				dj = j - cj;
				if (rm[i] && cm[j] && di >= -1 && di <= 1 && dj >= -1 && dj <= 1
						&& !(di == 0 && dj == 0) && !(w[ci][cj] < w[i][j]))
					ok = 1'b0;
			end
		end
		return ok;
	endfunction

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= top_s1;
			win_q[1][2] <= mid_s1;
			win_q[2][2] <= cell_s1;
			pos_s2      <= pos_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	assign rmask = {1'b1, pos_s2.row_ge1, pos_s2.row_ge2};
	assign cmask = {1'b1, pos_s2.col_ge1, pos_s2.col_ge2};

	// a cell is judged once its last existing neighbor has arrived
	always_comb begin
		hit_a = pos_s2.row_ge1 && pos_s2.col_ge1 && judge(win_q, 1, 1, rmask, cmask);
		hit_b = pos_s2.row_ge1 && pos_s2.last_col && judge(win_q, 1, 2, rmask, cmask);
		hit_c = pos_s2.last_row && pos_s2.col_ge1 && judge(win_q, 2, 1, rmask, cmask);
		hit_d = pos_s2.last_row && pos_s2.last_col && judge(win_q, 2, 2, rmask, cmask);
		hits  = 3'(hit_a) + 3'(hit_b) + 3'(hit_c) + 3'(hit_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s3 <= '0;
		end else begin
			hit_s3.valid <= valid_s2;
			if (valid_s2) begin
				hit_s3.frame_end <= pos_s2.last_row & pos_s2.last_col;
				hit_s3.hits      <= hits;
			end
		end
	end

endmodule

FILE: rtl/core/lmc_result.sv
// Running count per matrix and a small result queue toward the output channel.
// Depends on lmc_pkg. Fed by lmc_window.
module lmc_result
	import lmc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  logic               accept_last,
	input  lmc_hit_t           hit,
	output logic               full,
	output logic               count_valid,
	input  logic               count_ready,
	output logic [COUNT_W-1:0] minimum_count
);

	logic [COUNT_W-1:0] running_q;
	logic [COUNT_W-1:0] next_count;
	logic [COUNT_W-1:0] fifo_q [RES_DEPTH];
	logic [RES_PW-1:0]  wr_ptr_q;
	logic [RES_PW-1:0]  rd_ptr_q;
	logic [RES_CW-1:0]  fill_q;
	logic [RES_CW-1:0]  pend_q;
	logic               push;
	logic               take;

	assign next_count = running_q + COUNT_W'(hit.hits);
	assign push       = hit.valid & hit.frame_end;
	assign take       = count_valid & count_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			running_q <= '0;
		else if (restart)
			running_q <= '0;
		else if (hit.valid)
			running_q <= hit.frame_end ? '0 : next_count;
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= next_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			pend_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + RES_PW'(1);
			if (take)
				rd_ptr_q <= rd_ptr_q + RES_PW'(1);
			case ({push, take})
				2'b10:   fill_q <= fill_q + RES_CW'(1);
				2'b01:   fill_q <= fill_q - RES_CW'(1);
				default: fill_q <= fill_q;
			endcase
			// last cells accepted whose result is not yet taken
			case ({accept_last, take})
				2'b10:   pend_q <= pend_q + RES_CW'(1);
				2'b01:   pend_q <= pend_q - RES_CW'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	assign full          = (pend_q == RES_CW'(RES_DEPTH));
	assign count_valid   = (fill_q != '0);
	assign minimum_count = fifo_q[rd_ptr_q];

endmodule

FILE: rtl/core/local_minimum_counter_3x3.sv
// Top level of the 3x3 strict local minimum counter: register port, raster position,
// and the line store / window / result pipeline. Depends on lmc_pkg and all lmc_* modules.
//
// Usage:
//   Write row_count (address 0) and column_count (address 4) over the APB port while
//   the block is idle; each write restarts the matrix. Values are clamped to
//   1..MAX_ROWS and 1..MAX_COLUMNS, reads return the clamped value.
//   Send the matrix on cell_valid/cell_ready, one value per transaction, row by row.
//   After the last cell, one transaction on count_valid/count_ready carries the number
//   of cells strictly below all their existing 8-neighbors; the next matrix may follow
//   at once.
//   Throughput is one cell per clock while cell_ready is high. The line memory is read
//   when a cell is taken and written back the next cycle, so its single write port
//   sets that rate. Each count passes the s1, s2 and hit_s3 registers into the queue.
//   Up to 4 results queue behind a stalled receiver; cell_ready drops only on the last
//   cell of a matrix while 4 results are pending, other cells keep flowing.
//   Reset gives a 1x1 matrix, an empty queue and position zero. The line memory is not
//   cleared; entries not yet written for the current matrix are read but masked out.
module local_minimum_counter_3x3
	import lmc_pkg::*;
#(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 4096,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [CFG_AW-1:0]             paddr,
	input  logic [CFG_DW-1:0]             pwdata,
	output logic [CFG_DW-1:0]             prdata,
	output logic                          pready,
	input  logic                          cell_valid,
	output logic                          cell_ready,
	input  logic signed [VALUE_WIDTH-1:0] cell_value,
	output logic                          count_valid,
	input  logic                          count_ready,
	output logic [COUNT_W-1:0]            minimum_count
);

	localparam int CW  = $clog2(MAX_COLUMNS);
	localparam int CCW = $clog2(MAX_COLUMNS + 1);
	localparam int RPW = $clog2(MAX_ROWS);
	localparam int RCW = $clog2(MAX_ROWS + 1);

	logic [RCW-1:0]         rows_q;
	logic [CCW-1:0]         cols_q;
	logic [RCW-1:0]         row_clamped;
	logic [CCW-1:0]         col_clamped;
	logic [ROW_FIELD_W-1:0] row_field;
	logic [COL_FIELD_W-1:0] col_field;
	logic                   cfg_wr;
	lmc_reg_t               cfg_sel;

	logic [CW-1:0]  col_q;
	logic [RPW-1:0] row_q;
	lmc_pos_t       pos0;
	logic           accept;
	logic           res_full;

	logic                          valid_s1;
	logic signed [VALUE_WIDTH-1:0] cell_s1;
	logic signed [VALUE_WIDTH-1:0] top_s1;
	logic signed [VALUE_WIDTH-1:0] mid_s1;
	lmc_pos_t                      pos_s1;
	lmc_hit_t                      hit_s3;

	// register port
	assign pready    = 1'b1;
	assign cfg_wr    = psel & penable & pwrite & pready;
	assign cfg_sel   = lmc_reg_t'(paddr[2]);
	assign row_field = pwdata[ROW_FIELD_W-1:0];
	assign col_field = pwdata[COL_FIELD_W-1:0];

	always_comb begin
		if (row_field == '0)
			row_clamped = RCW'(1);
		else if (32'(row_field) > MAX_ROWS)
			row_clamped = RCW'(MAX_ROWS);
		else
			row_clamped = RCW'(row_field);
		if (col_field == '0)
			col_clamped = CCW'(1);
		else if (32'(col_field) > MAX_COLUMNS)
			col_clamped = CCW'(MAX_COLUMNS);
		else
			col_clamped = CCW'(col_field);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RCW'(1);
			cols_q <= CCW'(1);
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_ROW_COUNT:    rows_q <= row_clamped;
				REG_COLUMN_COUNT: cols_q <= col_clamped;
				default:          rows_q <= rows_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_ROW_COUNT:    prdata = CFG_DW'(rows_q);
			REG_COLUMN_COUNT: prdata = CFG_DW'(cols_q);
			default:          prdata = '0;
		endcase
	end

	// raster position of the next cell
	assign pos0.row_ge1  = (row_q != '0);
	assign pos0.row_ge2  = (row_q > RPW'(1));
	assign pos0.col_ge1  = (col_q != '0);
	assign pos0.col_ge2  = (col_q > CW'(1));
	assign pos0.last_row = ((RCW'(row_q) + RCW'(1)) == rows_q);
	assign pos0.last_col = ((CCW'(col_q) + CCW'(1)) == cols_q);

	assign cell_ready = !(pos0.last_row && pos0.last_col && res_full);
	assign accept     = cell_valid & cell_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pos0.last_col) begin
				col_q <= '0;
				row_q <= pos0.last_row ? '0 : row_q + RPW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	lmc_line_mem #(
		.VW    (VALUE_WIDTH),
		.DEPTH (MAX_COLUMNS)
	) u_line_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (col_q),
		.cell_in  (cell_value),
		.pos      (pos0),
		.valid_s1 (valid_s1),
		.cell_s1  (cell_s1),
		.top_s1   (top_s1),
		.mid_s1   (mid_s1),
		.pos_s1   (pos_s1)
	);

	lmc_window #(
		.VW (VALUE_WIDTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.cell_s1  (cell_s1),
		.top_s1   (top_s1),
		.mid_s1   (mid_s1),
		.pos_s1   (pos_s1),
		.hit_s3   (hit_s3)
	);

	lmc_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (cfg_wr),
		.accept_last   (accept & pos0.last_row & pos0.last_col),
		.hit           (hit_s3),
		.full          (res_full),
		.count_valid   (count_valid),
		.count_ready   (count_ready),
		.minimum_count (minimum_count)
	);

endmodule

FILE: rtl/core/lmc_checker.sv
// Port-level checks for local_minimum_counter_3x3, bound to the top level.
// Depends on lmc_pkg for the result width.
module lmc_checker
	import lmc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               cell_valid,
	input logic               cell_ready,
	input logic               count_valid,
	input logic               count_ready,
	input logic [COUNT_W-1:0] minimum_count
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		count_valid && !count_ready |=> count_valid && $stable(minimum_count))
		else $error("result changed or dropped while stalled");

	// a rising count_valid must trace back to a cell transaction through the pipeline registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(count_valid) |-> $past(cell_valid && cell_ready, 4))
		else $error("result appeared without a cell transaction 4 cycles earlier");

	// reset empties the result queue
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !count_valid)
		else $error("result valid right after reset");

endmodule

bind local_minimum_counter_3x3 lmc_checker u_lmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cell_valid    (cell_valid),
	.cell_ready    (cell_ready),
	.count_valid   (count_valid),
	.count_ready   (count_ready),
	.minimum_count (minimum_count)
);

FILE: test/local_minimum_counter_3x3_tb.sv
// Self-checking testbench for local_minimum_counter_3x3: APB setup, raster cell stream, count check.
// Depends on lmc_pkg and the block's RTL; expected counts come from a behavioral predictor below.
`timescale 1ns / 1ps

module local_minimum_counter_3x3_tb;
	import lmc_pkg::*;

	localparam int MAX_COLUMNS    = 1024;
	localparam int MAX_ROWS       = 4096;
	localparam int VALUE_WIDTH    = 16;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef logic signed [VALUE_WIDTH-1:0] cell_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_AW-1:0]        paddr;
	logic [CFG_DW-1:0]        pwdata;
	logic [CFG_DW-1:0]        prdata;
	logic                     pready;
	logic                     cell_valid;
	logic                     cell_ready;
	cell_t                    cell_value;
	logic                     count_valid;
	logic                     count_ready;
	logic [COUNT_W-1:0]       minimum_count;

	local_minimum_counter_3x3 #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.cell_valid   (cell_valid),
		.cell_ready   (cell_ready),
		.cell_value   (cell_value),
		.count_valid  (count_valid),
		.count_ready  (count_ready),
		.minimum_count(minimum_count)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state
	// ------------------------------------------------------------------
	cell_t              upper_line    [MAX_COLUMNS];
	cell_t              middle_line   [MAX_COLUMNS];
	cell_t              incoming_line [MAX_COLUMNS];
	int                 rows_cfg = 1;
	int                 cols_cfg = 1;
	int                 row_pos  = 0;
	int                 col_pos  = 0;
	logic [COUNT_W-1:0] tally    = '0;
	logic [COUNT_W-1:0] count_expected[$];

	bit failed        = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request  = 0;
	int hold_left     = 0;
	int cells_offered = 0;
	int idle_cycles   = 0;

	// Judges one full row. last_row picks the incoming row (no row below),
	// otherwise the middle row is judged against upper (when present) and incoming.
	function automatic int minima_in_row(input bit last_row, input bit have_above);
		int    hits;
		int    lo;
		int    hi;
		cell_t v;
		cell_t nb;
		bit    ok;
		hits = 0;
		for (int c = 0; c < cols_cfg; c++) begin
			v  = last_row ? incoming_line[c] : middle_line[c];
			lo = (c > 0) ? c - 1 : c;
			hi = (c + 1 < cols_cfg) ? c + 1 : c;
			ok = 1'b1;
			for (int k = lo; k <= hi; k++) begin
				if (have_above) begin
					nb = last_row ? middle_line[k] : upper_line[k];
					if (!(v < nb)) ok = 1'b0;
				end
				if (!last_row && !(v < incoming_line[k])) ok = 1'b0;
				if (k != c) begin
					nb = last_row ? incoming_line[k] : middle_line[k];
					if (!(v < nb)) ok = 1'b0;
				end
			end
			if (ok) hits++;
		end
		return hits;
	endfunction

	function automatic void take_cell(input cell_t v);
		int col;
		col = col_pos;
		if (col >= cols_cfg) col = cols_cfg - 1;
		incoming_line[col] = v;
		if (col + 1 < cols_cfg) begin
			col_pos = col + 1;
			return;
		end
		if (row_pos > 0) tally = tally + COUNT_W'(minima_in_row(1'b0, row_pos > 1));
		if (row_pos + 1 >= rows_cfg) begin
			tally = tally + COUNT_W'(minima_in_row(1'b1, row_pos > 0));
			count_expected.push_back(tally);
			row_pos = 0;
			col_pos = 0;
			tally   = '0;
			return;
		end
		for (int c = 0; c < cols_cfg; c++) begin
			upper_line[c]  = middle_line[c];
			middle_line[c] = incoming_line[c];
		end
		row_pos = row_pos + 1;
		col_pos = 0;
	endfunction

	function automatic void apply_register(input lmc_reg_t r, input logic [CFG_DW-1:0] data);
		int v;
		if (r == REG_ROW_COUNT) begin
			v = int'(data[ROW_FIELD_W-1:0]);
			rows_cfg = (v < 1) ? 1 : (v > MAX_ROWS) ? MAX_ROWS : v;
		end else begin
			v = int'(data[COL_FIELD_W-1:0]);
			cols_cfg = (v < 1) ? 1 : (v > MAX_COLUMNS) ? MAX_COLUMNS : v;
		end
		row_pos = 0;
		col_pos = 0;
		tally   = '0;
	endfunction

	// ------------------------------------------------------------------
	// Count receiver and checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && count_valid && count_ready) begin
			if (count_expected.size() == 0) begin
				$error("minimum_count: no count expected, got %0d", minimum_count);
				failed = 1'b1;
			end else if (minimum_count !== count_expected[0]) begin
				$error("minimum_count: expected %0d, got %0d", count_expected[0], minimum_count);
				failed = 1'b1;
				void'(count_expected.pop_front());
			end else begin
				void'(count_expected.pop_front());
			end
		end
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left   = hold_left - 1;
			count_ready <= 1'b0;
		end else begin
			count_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: ends the run once no transaction of any kind happens for too long
	always @(posedge clk) begin
		if (!arst_n || (cell_valid && cell_ready) || (count_valid && count_ready)
				|| (psel && penable && pready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic offer_cell(input cell_t v);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			cell_valid <= 1'b0;
			cell_value <= cell_t'($urandom());
			repeat (gap) @(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_value <= v;
		do @(posedge clk); while (!cell_ready);
		take_cell(v);
		cells_offered++;
	endtask

	// Lower valid and wait until the block has nothing left in flight
	task automatic settle();
		cell_valid <= 1'b0;
		while (count_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input lmc_reg_t r, input logic [CFG_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_register(r, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input lmc_reg_t r);
		logic [CFG_DW-1:0] want;
		want    = (r == REG_ROW_COUNT) ? CFG_DW'(rows_cfg) : CFG_DW'(cols_cfg);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {r, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("prdata: expected %0d, got %0d", want, prdata);
			failed = 1'b1;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Half tiny values so ties and minima are frequent, the rest full range and extremes
	function automatic cell_t random_cell_value();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return cell_t'(int'($urandom_range(4)) - 2);
			5, 6, 7:       return cell_t'($urandom());
			8:             return $urandom_range(1) ? cell_t'(16'h8000) : cell_t'(16'h7fff);
			default:       return $urandom_range(1) ? cell_t'(-1) : cell_t'(16'h8001);
		endcase
	endfunction

	task automatic send_matrix(input int n_rows, input int n_cols);
		repeat (n_rows * n_cols) offer_cell(random_cell_value());
	endtask

	task automatic send_list(input cell_t vals[$]);
		foreach (vals[i]) offer_cell(vals[i]);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_reset_defaults();
		cell_t vals[$];
		check_register(REG_ROW_COUNT);
		check_register(REG_COLUMN_COUNT);
		// 1x1 after reset: every cell is a matrix of its own
		vals = '{cell_t'(16'h8000), cell_t'(16'h7fff), cell_t'(0)};
		send_list(vals);
		settle();
	endtask

	task automatic test_directed_shapes();
		cell_t vals[$];
		// single row with equal neighbors
		write_register(REG_ROW_COUNT, 1);
		write_register(REG_COLUMN_COUNT, 5);
		vals = '{cell_t'(3), cell_t'(1), cell_t'(1), cell_t'(5), cell_t'(-2)};
		send_list(vals);
		settle();
		// single column
		write_register(REG_ROW_COUNT, 4);
		write_register(REG_COLUMN_COUNT, 1);
		vals = '{cell_t'(0), cell_t'(-1), cell_t'(7), cell_t'(16'h8000)};
		send_list(vals);
		settle();
		// 3x3 with a clear center minimum
		write_register(REG_ROW_COUNT, 3);
		write_register(REG_COLUMN_COUNT, 3);
		vals = '{cell_t'(5), cell_t'(6), cell_t'(7), cell_t'(4), cell_t'(-9),
			cell_t'(8), cell_t'(3), cell_t'(2), cell_t'(1)};
		send_list(vals);
		settle();
		// 2x2 extremes, diagonal tie on the minimum
		write_register(REG_ROW_COUNT, 2);
		write_register(REG_COLUMN_COUNT, 2);
		vals = '{cell_t'(16'h8000), cell_t'(16'h7fff), cell_t'(16'h7fff), cell_t'(16'h8000)};
		send_list(vals);
		settle();
	endtask

	task automatic test_register_clamps();
		write_register(REG_ROW_COUNT, 0);
		check_register(REG_ROW_COUNT);
		write_register(REG_ROW_COUNT, 32'hffff_ffff);
		check_register(REG_ROW_COUNT);
		write_register(REG_COLUMN_COUNT, 0);
		check_register(REG_COLUMN_COUNT);
		write_register(REG_COLUMN_COUNT, 32'hffff_f7ff);
		check_register(REG_COLUMN_COUNT);
		// upper bits are junk, field gives one row
		write_register(REG_ROW_COUNT, 32'habcd_e001);
		check_register(REG_ROW_COUNT);
		// long single row
		write_register(REG_COLUMN_COUNT, 96);
		send_matrix(rows_cfg, cols_cfg);
		settle();
		// tall single column
		write_register(REG_ROW_COUNT, 40);
		write_register(REG_COLUMN_COUNT, 1);
		check_register(REG_ROW_COUNT);
		send_matrix(rows_cfg, cols_cfg);
		settle();
	endtask

	task automatic test_restart_midframe();
		write_register(REG_ROW_COUNT, 3);
		write_register(REG_COLUMN_COUNT, 4);
		repeat (5) offer_cell(random_cell_value());
		settle();
		// same value again still throws away the partial matrix
		write_register(REG_COLUMN_COUNT, 4);
		send_matrix(3, 4);
		settle();
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_register(REG_ROW_COUNT, 1);
		write_register(REG_COLUMN_COUNT, 1);
		// receiver stalls while 1x1 matrices keep coming, result queue fills up
		hold_request = 300;
		repeat (30) offer_cell(random_cell_value());
		settle();
		// two-row matrices back to back against a short stall
		write_register(REG_ROW_COUNT, 2);
		write_register(REG_COLUMN_COUNT, 2);
		hold_request = 120;
		repeat (12) send_matrix(2, 2);
		settle();
	endtask

	task automatic test_random_matrices(input int send_pct, input int recv_pct,
			input int cell_target);
		int                n_rows;
		int                n_cols;
		int                start;
		logic [CFG_DW-1:0] junk;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		start          = cells_offered;
		while (cells_offered - start < cell_target) begin
			if (cells_offered == start || $urandom_range(1) == 0) begin
				n_rows = $urandom_range(1, 6);
				n_cols = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				settle();
				junk = $urandom_range(3) == 0 ? $urandom() : '0;
				write_register(REG_ROW_COUNT,
					(junk & ~CFG_DW'((1 << ROW_FIELD_W) - 1)) | CFG_DW'(n_rows));
				write_register(REG_COLUMN_COUNT,
					(junk & ~CFG_DW'((1 << COL_FIELD_W) - 1)) | CFG_DW'(n_cols));
			end
			send_matrix(rows_cfg, cols_cfg);
		end
		settle();
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		cell_valid  = 1'b0;
		cell_value  = '0;
		count_ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_shapes();
		test_register_clamps();
		test_restart_midframe();
		test_backpressure();
		test_random_matrices(0, 0, 100);
		test_random_matrices(80, 0, 100);
		test_random_matrices(0, 80, 100);
		test_random_matrices(24, 24, 100);

		if (!failed && count_expected.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/lmc_pkg.sv
rtl/core/lmc_line_mem.sv
rtl/core/lmc_window.sv
rtl/core/lmc_result.sv
rtl/core/local_minimum_counter_3x3.sv
rtl/core/lmc_checker.sv
test/local_minimum_counter_3x3_tb.sv
